FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the error statistics block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PES_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pes assertion failed");
`define PES_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("pes forbidden condition");
`else
`define PES_ASSERT(label, clk, rst_n, prop)
`define PES_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

FILE: design/pes_pkg.sv
// ----------------------------------------------------------------------------
// pes_pkg
// Types and constants of the prediction error statistics block.
// ----------------------------------------------------------------------------
`default_nettype none
package pes_pkg;
    localparam int MAX_SAMPLES = 4096;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 8;
    localparam int CNT_W       = 13;
    localparam int DVD_W       = 64;
    localparam int DVS_W       = 32;
    localparam int STEP_W      = 7;

    typedef struct packed {
        logic [15:0] actual;
        logic [15:0] predicted;
        logic        is_last;
    } t_in_req;

    typedef struct packed {
        logic [23:0] mean_abs_error;
        logic [23:0] rms_error;
        logic [31:0] mean_pct_error;
        logic [12:0] sample_total;
        logic        overflowed;
    } t_out_req;

    typedef struct packed {
        logic               start;
        logic [DVD_W-1:0]   dividend;
        logic [DVS_W-1:0]   divisor;
        logic [STEP_W-1:0]  steps;
    } t_div_cmd;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic        start;
        logic [63:0] radicand;
    } t_sqrt_cmd;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] root;
    } t_sqrt_rsp;
endpackage
`default_nettype wire

FILE: design/pes_front.sv
// ----------------------------------------------------------------------------
// pes_front
// Accepts sample pairs and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module pes_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire pes_pkg::t_in_req  i_req,
    output logic                   o_q_valid,
    output pes_pkg::t_in_req       o_q_data,
    input  wire logic              i_pop
);
    pes_pkg::t_in_req r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_stall   = (r_cnt == 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_data  = r_mem[r_rp];
    assign w_push    = i_valid && !o_stall;
    assign w_pop     = i_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_mem[r_wp] <= i_req;
                r_wp        <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: design/pes_divider.sv
// ----------------------------------------------------------------------------
// pes_divider
// Restoring divider, one quotient bit per cycle over a left-aligned dividend.
// ----------------------------------------------------------------------------
`default_nettype none
module pes_divider (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pes_pkg::t_div_cmd i_cmd,
    output pes_pkg::t_div_rsp      o_rsp
);
    logic                          r_busy, r_done;
    logic [pes_pkg::STEP_W-1:0]    r_cnt;
    logic [pes_pkg::DVD_W-1:0]     r_dvd, r_quo;
    logic [pes_pkg::DVS_W-1:0]     r_dvs, r_rem;
    logic [pes_pkg::DVS_W:0]       w_rem_sh, w_sub;
    logic                          w_ge;

    assign w_rem_sh = {r_rem, r_dvd[pes_pkg::DVD_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_dvs});
    assign w_sub    = w_rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_dvd  <= i_cmd.dividend;
                r_dvs  <= i_cmd.divisor;
                r_rem  <= '0;
                r_quo  <= '0;
                r_cnt  <= i_cmd.steps;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_sub[pes_pkg::DVS_W-1:0] : w_rem_sh[pes_pkg::DVS_W-1:0];
                r_dvd <= {r_dvd[pes_pkg::DVD_W-2:0], 1'b0};
                r_quo <= {r_quo[pes_pkg::DVD_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == pes_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule
`default_nettype wire

FILE: design/pes_sqrt.sv
// ----------------------------------------------------------------------------
// pes_sqrt
// Digit-by-digit integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pes_sqrt (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire pes_pkg::t_sqrt_cmd i_cmd,
    output pes_pkg::t_sqrt_rsp      o_rsp
);
    logic        r_busy, r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_val;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [35:0] w_rem_sh, w_trial, w_sub;
    logic        w_ge;

    assign w_rem_sh = {r_rem, r_val[63:62]};
    assign w_trial  = {2'b00, r_root, 2'b01};
    assign w_ge     = (w_rem_sh >= w_trial);
    assign w_sub    = w_rem_sh - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_val  <= i_cmd.radicand;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= 5'd31;
            end else if (r_busy) begin
                r_rem  <= w_ge ? w_sub[33:0] : w_rem_sh[33:0];
                r_val  <= {r_val[61:0], 2'b00};
                r_root <= {r_root[30:0], w_ge};
                r_cnt  <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;
endmodule
`default_nettype wire

FILE: design/pes_back.sv
// ----------------------------------------------------------------------------
// pes_back
// Accumulates queued pairs and computes the closing statistics of a set.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module pes_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire pes_pkg::t_in_req  i_q_data,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output pes_pkg::t_out_req      o_resp
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_ACC  = 8'b0000_0010,
        S_RDIV = 8'b0000_0100,
        S_MAE  = 8'b0000_1000,
        S_MSQ  = 8'b0001_0000,
        S_SQRT = 8'b0010_0000,
        S_PCT  = 8'b0100_0000,
        S_EMIT = 8'b1000_0000
    } t_state;

    t_state                     r_state;
    logic                       r_launch;
    logic [15:0]                r_act, r_diff;
    logic                       r_last;
    logic [27:0]                r_abs;
    logic [43:0]                r_sq, r_ratio;
    logic [pes_pkg::CNT_W-1:0]  r_count;
    logic                       r_drop;
    logic [50:0]                r_pct_num;
    logic [63:0]                r_msq;
    logic [23:0]                r_mae, r_rms;
    logic [31:0]                r_pct;
    logic                       r_out_valid;
    pes_pkg::t_out_req          r_out;

    logic [15:0]                w_a, w_p;
    logic                       w_take, w_load;
    logic [pes_pkg::CNT_W-1:0]  w_n;
    logic [31:0]                w_sq;
    pes_pkg::t_div_cmd          w_div_cmd;
    pes_pkg::t_div_rsp          w_div_rsp;
    pes_pkg::t_sqrt_cmd         w_sqrt_cmd;
    pes_pkg::t_sqrt_rsp         w_sqrt_rsp;

    assign w_a    = 16'(i_q_data.actual[pes_pkg::SAMPLE_BITS-1:0]);
    assign w_p    = 16'(i_q_data.predicted[pes_pkg::SAMPLE_BITS-1:0]);
    assign o_pop  = i_q_valid && (r_state == S_IDLE);
    assign w_take = (r_count < pes_pkg::CNT_W'(pes_pkg::MAX_SAMPLES));
    assign w_n    = (r_count == '0) ? pes_pkg::CNT_W'(1) : r_count;
    assign w_sq   = r_diff * r_diff;
    assign w_load = (r_state == S_EMIT) && (!r_out_valid || !i_stall);

    always_comb begin
        w_div_cmd.start    = r_launch && (r_state == S_RDIV || r_state == S_MAE ||
                                          r_state == S_MSQ || r_state == S_PCT);
        w_div_cmd.dividend = {r_diff, 48'd0};
        w_div_cmd.divisor  = {16'd0, r_act};
        w_div_cmd.steps    = pes_pkg::STEP_W'(32);
        case (r_state)
            S_MAE: begin
                w_div_cmd.dividend = {r_abs, 8'd0, 28'd0};
                w_div_cmd.divisor  = {19'd0, w_n};
                w_div_cmd.steps    = pes_pkg::STEP_W'(36);
            end
            S_MSQ: begin
                w_div_cmd.dividend = {r_sq, 16'd0, 4'd0};
                w_div_cmd.divisor  = {19'd0, w_n};
                w_div_cmd.steps    = pes_pkg::STEP_W'(60);
            end
            S_PCT: begin
                w_div_cmd.dividend = {r_pct_num, 13'd0};
                w_div_cmd.divisor  = {11'd0, w_n, 8'd0};
                w_div_cmd.steps    = pes_pkg::STEP_W'(51);
            end
            default: begin
            end
        endcase
        w_sqrt_cmd.start    = r_launch && (r_state == S_SQRT);
        w_sqrt_cmd.radicand = r_msq;
    end

    pes_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_div_cmd),
        .o_rsp   (w_div_rsp)
    );

    pes_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_sqrt_cmd),
        .o_rsp   (w_sqrt_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_launch    <= 1'b0;
            r_abs       <= '0;
            r_sq        <= '0;
            r_ratio     <= '0;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_launch <= 1'b0;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_act   <= w_a;
                        r_diff  <= (w_p >= w_a) ? (w_p - w_a) : (w_a - w_p);
                        r_last  <= i_q_data.is_last;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (w_take) begin
                        r_abs   <= r_abs + {12'd0, r_diff};
                        r_sq    <= r_sq + {12'd0, w_sq};
                        r_count <= r_count + 1'b1;
                    end else begin
                        r_drop <= 1'b1;
                    end
                    if (w_take && r_act != 16'd0) begin
                        r_state  <= S_RDIV;
                        r_launch <= 1'b1;
                    end else if (r_last) begin
                        r_state  <= S_MAE;
                        r_launch <= 1'b1;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_RDIV: begin
                    if (w_div_rsp.done) begin
                        r_ratio <= r_ratio + {12'd0, w_div_rsp.quotient[31:0]};
                        if (r_last) begin
                            r_state  <= S_MAE;
                            r_launch <= 1'b1;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_MAE: begin
                    if (w_div_rsp.done) begin
                        r_mae     <= (|w_div_rsp.quotient[63:24]) ? 24'hFF_FFFF
                                                                  : w_div_rsp.quotient[23:0];
                        r_pct_num <= {1'b0, r_ratio, 6'd0} + {2'b0, r_ratio, 5'd0}
                                   + {5'd0, r_ratio, 2'd0};
                        r_state   <= S_MSQ;
                        r_launch  <= 1'b1;
                    end
                end
                S_MSQ: begin
                    if (w_div_rsp.done) begin
                        r_msq    <= w_div_rsp.quotient;
                        r_state  <= S_SQRT;
                        r_launch <= 1'b1;
                    end
                end
                S_SQRT: begin
                    if (w_sqrt_rsp.done) begin
                        r_rms    <= (|w_sqrt_rsp.root[31:24]) ? 24'hFF_FFFF
                                                              : w_sqrt_rsp.root[23:0];
                        r_state  <= S_PCT;
                        r_launch <= 1'b1;
                    end
                end
                S_PCT: begin
                    if (w_div_rsp.done) begin
                        r_pct   <= (|w_div_rsp.quotient[63:32]) ? 32'hFFFF_FFFF
                                                                : w_div_rsp.quotient[31:0];
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_load) begin
                        r_out.mean_abs_error <= r_mae;
                        r_out.rms_error      <= r_rms;
                        r_out.mean_pct_error <= r_pct;
                        r_out.sample_total   <= r_count;
                        r_out.overflowed     <= r_drop;
                        r_abs                <= '0;
                        r_sq                 <= '0;
                        r_ratio              <= '0;
                        r_count              <= '0;
                        r_drop               <= 1'b0;
                        r_state              <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_resp  = r_out;

    `PES_ASSERT(a_count_cap, i_clk, i_rst_n, r_count <= pes_pkg::CNT_W'(pes_pkg::MAX_SAMPLES))
    `PES_ASSERT_NEVER(a_div_overlap, i_clk, i_rst_n, w_div_cmd.start && w_div_rsp.busy)
    `PES_ASSERT(a_total_nonzero, i_clk, i_rst_n, w_load |=> r_out.sample_total != '0)
endmodule
`default_nettype wire

FILE: design/prediction_error_stats_core.sv
// ----------------------------------------------------------------------------
// prediction_error_stats_core
// Mean absolute, root mean squared and mean percentage error over sample sets.
// ----------------------------------------------------------------------------
// A pair of samples with a nonzero actual value that is counted also waits for
// the 32-step ratio division in the shared one-bit-per-cycle divider; a pair
// with a zero actual value skips it. A closing pair adds the three result
// divisions (36, 60 and 51 steps) and the 32-step square root. A two-entry
// request queue in front lets the sender run ahead, and the result register
// lets a new set be accumulated while the last result waits.
`default_nettype none
module prediction_error_stats_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire pes_pkg::t_in_req  i_req,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output pes_pkg::t_out_req      o_resp
);
    logic             w_q_valid, w_pop;
    pes_pkg::t_in_req w_q_data;

    pes_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_req     (i_req),
        .o_q_valid (w_q_valid),
        .o_q_data  (w_q_data),
        .i_pop     (w_pop)
    );

    pes_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_data),
        .o_pop     (w_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_resp    (o_resp)
    );
endmodule
`default_nettype wire
